[hw/rtl/assert_macros.svh]
// Assertion macros for the checker module.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i and disabled during reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Concurrent assertion that also runs during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");
`endif

[hw/rtl/acpu_pkg.sv]
// Package for the accumulator CPU: opcodes, functions, status codes and the
// controller/datapath command and status structures. Depends on nothing.
`timescale 1ns / 1ps
package acpu_pkg;

  localparam int unsigned WordW = 40;
  localparam int unsigned RegW  = 32;
  localparam int unsigned PcW   = 12;
  localparam int unsigned LimW  = 13;
  localparam int unsigned HalfW = 20;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_EXEC  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_END     = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_LIMIT   = 2'd3
  } status_e;

  localparam logic [7:0] OpStore = 8'h21;
  localparam logic [7:0] OpLoad  = 8'h01;
  localparam logic [7:0] OpJump  = 8'h0D;
  localparam logic [7:0] OpJumpP = 8'h0F;
  localparam logic [7:0] OpAdd   = 8'h05;
  localparam logic [7:0] OpSub   = 8'h06;
  localparam logic [7:0] OpMul   = 8'h0B;
  localparam logic [7:0] OpDiv   = 8'h0C;
  localparam logic [7:0] OpEnd   = 8'hFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HOSTRD,
    S_FETCH,
    S_DECODE,
    S_OPRD,
    S_EXEC,
    S_MUL,
    S_DIVSETUP,
    S_DIV,
    S_DIVFIX,
    S_CHECK,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the input beat
    logic host_wr;   // write the host word
    logic host_rd;   // read the host word into the read register
    logic clr_rd;    // zero the read register
    logic fetch_rd;  // read memory at pc
    logic fetch_use; // take fetched word: bump pc, buffer right half
    logic buf_use;   // take buffered half, empty the buffer
    logic op_rd;     // read memory at instruction address
    logic exec;      // simple instructions and halt settings
    logic mul;       // register the product into acc
    logic div_init;  // load divider operands
    logic div_step;  // one quotient bit
    logic div_fix;   // sign fix and write acc/mq
    logic limit_chk; // set halt at limit
    logic pre_limit; // set halt at limit before running
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e      func;
    logic       halted;
    logic       at_limit;
    logic       buf_empty;
    logic [7:0] opcode;
    logic       div_zero;
    logic       div_done;
  } stat_t;

endpackage

[hw/rtl/acpu_ctrl.sv]
// Controller state machine of the accumulator CPU.
// Depends on acpu_pkg.
`timescale 1ns / 1ps
module acpu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  acpu_pkg::stat_t stat_i,
  output acpu_pkg::cmd_t  cmd_o
);

  acpu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acpu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acpu_pkg::S_IDLE: if (in_valid_i) state_d = acpu_pkg::S_HOSTRD;
      acpu_pkg::S_HOSTRD: begin
        if (stat_i.func == acpu_pkg::FUNC_EXEC && !stat_i.halted) begin
          state_d = acpu_pkg::S_FETCH;
        end else begin
          state_d = acpu_pkg::S_OUT;
        end
      end
      acpu_pkg::S_FETCH: begin
        state_d = stat_i.at_limit ? acpu_pkg::S_OUT : acpu_pkg::S_DECODE;
      end
      acpu_pkg::S_DECODE: state_d = acpu_pkg::S_OPRD;
      acpu_pkg::S_OPRD: state_d = acpu_pkg::S_EXEC;
      acpu_pkg::S_EXEC: begin
        priority case (stat_i.opcode)
          acpu_pkg::OpMul: state_d = acpu_pkg::S_MUL;
          acpu_pkg::OpDiv: begin
            state_d = stat_i.div_zero ? acpu_pkg::S_CHECK : acpu_pkg::S_DIVSETUP;
          end
          default: state_d = acpu_pkg::S_CHECK;
        endcase
      end
      acpu_pkg::S_MUL: state_d = acpu_pkg::S_CHECK;
      acpu_pkg::S_DIVSETUP: state_d = acpu_pkg::S_DIV;
      acpu_pkg::S_DIV: if (stat_i.div_done) state_d = acpu_pkg::S_DIVFIX;
      acpu_pkg::S_DIVFIX: state_d = acpu_pkg::S_CHECK;
      acpu_pkg::S_CHECK: state_d = acpu_pkg::S_OUT;
      acpu_pkg::S_OUT: if (out_ready_i) state_d = acpu_pkg::S_IDLE;
      default: state_d = acpu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      acpu_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      acpu_pkg::S_HOSTRD: begin
        cmd_o.host_wr = (stat_i.func == acpu_pkg::FUNC_WRITE);
        cmd_o.host_rd = (stat_i.func == acpu_pkg::FUNC_READ);
        cmd_o.clr_rd  = (stat_i.func != acpu_pkg::FUNC_READ);
      end
      acpu_pkg::S_FETCH: begin
        cmd_o.pre_limit = stat_i.at_limit;
        cmd_o.fetch_rd  = !stat_i.at_limit && stat_i.buf_empty;
      end
      acpu_pkg::S_DECODE: begin
        cmd_o.fetch_use = stat_i.buf_empty;
        cmd_o.buf_use   = !stat_i.buf_empty;
      end
      acpu_pkg::S_OPRD: cmd_o.op_rd = 1'b1;
      acpu_pkg::S_EXEC: cmd_o.exec = 1'b1;
      acpu_pkg::S_MUL: cmd_o.mul = 1'b1;
      acpu_pkg::S_DIVSETUP: cmd_o.div_init = 1'b1;
      acpu_pkg::S_DIV: cmd_o.div_step = 1'b1;
      acpu_pkg::S_DIVFIX: cmd_o.div_fix = 1'b1;
      acpu_pkg::S_CHECK: cmd_o.limit_chk = 1'b1;
      acpu_pkg::S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

[hw/rtl/acpu_dpath.sv]
// Datapath of the accumulator CPU: word memory, registers, multiplier and a
// radix-2 divider. Depends on acpu_pkg.
`timescale 1ns / 1ps
module acpu_dpath #(
  parameter int unsigned MemWords = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  acpu_pkg::cmd_t             cmd_i,
  output acpu_pkg::stat_t            stat_o,
  input  logic [1:0]                 func_i,
  input  logic [acpu_pkg::PcW-1:0]   address_i,
  input  logic [acpu_pkg::WordW-1:0] write_data_i,
  input  logic                       cfg_valid_i,
  input  logic [acpu_pkg::LimW-1:0]  cfg_data_i,
  output logic [acpu_pkg::WordW-1:0] read_data_o,
  output logic [acpu_pkg::RegW-1:0]  acc_o,
  output logic [acpu_pkg::RegW-1:0]  mq_o,
  output logic [acpu_pkg::PcW-1:0]   pc_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned AddrW = $clog2(MemWords);
  localparam int unsigned CntW  = 6;

  logic [acpu_pkg::WordW-1:0] mem_q [MemWords];
  logic [acpu_pkg::WordW-1:0] rdata_q;

  acpu_pkg::func_e            func_q;
  logic [acpu_pkg::PcW-1:0]   addr_q;
  logic [acpu_pkg::WordW-1:0] wdata_q;
  logic [acpu_pkg::WordW-1:0] read_q;
  logic [acpu_pkg::RegW-1:0]  acc_q, mq_q;
  logic [acpu_pkg::PcW-1:0]   pc_q;
  logic [acpu_pkg::HalfW-1:0] buf_q, half_q;
  acpu_pkg::status_e          halt_q;
  logic [acpu_pkg::LimW-1:0]  limit_q;

  // Divider state: magnitudes, partial remainder and quotient.
  logic [acpu_pkg::WordW-1:0] dvs_q;
  logic [acpu_pkg::RegW:0]    rem_q;
  logic [acpu_pkg::RegW-1:0]  quo_q;
  logic [CntW-1:0]            cnt_q;
  logic                       qneg_q, rneg_q;

  logic [7:0]                 opcode;
  logic [acpu_pkg::PcW-1:0]   iaddr;
  logic [AddrW-1:0]           mem_addr;
  logic                       mem_we;
  logic [acpu_pkg::WordW-1:0] mem_wdata;
  logic [acpu_pkg::RegW-1:0]  low;
  logic                       dvs_neg;
  logic [acpu_pkg::WordW-1:0] dvs_mag;
  logic [acpu_pkg::RegW:0]    rem_sh;
  logic [acpu_pkg::WordW:0]   rem_cmp;
  logic                       sub_ok;

  assign opcode = half_q[acpu_pkg::HalfW-1 -: 8];
  assign iaddr  = half_q[acpu_pkg::PcW-1:0];
  assign low    = rdata_q[acpu_pkg::RegW-1:0];

  always_comb begin
    mem_addr  = addr_q[AddrW-1:0];
    mem_we    = 1'b0;
    mem_wdata = wdata_q;
    if (cmd_i.fetch_rd) begin
      mem_addr = pc_q[AddrW-1:0];
    end else if (cmd_i.op_rd || cmd_i.exec) begin
      mem_addr = iaddr[AddrW-1:0];
    end else if (cmd_i.capture) begin
      // Start the host read in the accepting cycle so the word is ready next cycle.
      mem_addr = address_i[AddrW-1:0];
    end
    if (cmd_i.host_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.exec && opcode == acpu_pkg::OpStore) begin
      mem_we    = 1'b1;
      mem_wdata = {{(acpu_pkg::WordW-acpu_pkg::RegW){acc_q[acpu_pkg::RegW-1]}}, acc_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  assign dvs_neg = rdata_q[acpu_pkg::WordW-1];
  assign dvs_mag = dvs_neg ? (~rdata_q + 1'b1) : rdata_q;
  assign rem_sh  = {rem_q[acpu_pkg::RegW-1:0], quo_q[acpu_pkg::RegW-1]};
  assign rem_cmp = {{(acpu_pkg::WordW-acpu_pkg::RegW){1'b0}}, rem_sh} - {1'b0, dvs_q};
  assign sub_ok  = !rem_cmp[acpu_pkg::WordW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= acpu_pkg::func_e'(func_i);
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.host_rd) begin
      read_q <= rdata_q;
    end else if (cmd_i.clr_rd) begin
      read_q <= '0;
    end
    if (cmd_i.fetch_use) begin
      half_q <= rdata_q[acpu_pkg::WordW-1 -: acpu_pkg::HalfW];
    end else if (cmd_i.buf_use) begin
      half_q <= buf_q;
    end
    if (cmd_i.div_init) begin
      dvs_q  <= dvs_mag;
      rem_q  <= '0;
      quo_q  <= acc_q[acpu_pkg::RegW-1] ? (~acc_q + 1'b1) : acc_q;
      cnt_q  <= '0;
      qneg_q <= acc_q[acpu_pkg::RegW-1] ^ dvs_neg;
      rneg_q <= acc_q[acpu_pkg::RegW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= sub_ok ? rem_cmp[acpu_pkg::RegW:0] : rem_sh;
      quo_q <= {quo_q[acpu_pkg::RegW-2:0], sub_ok};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      mq_q    <= '0;
      pc_q    <= '0;
      buf_q   <= '0;
      halt_q  <= acpu_pkg::ST_RUN;
      limit_q <= acpu_pkg::LimW'(10);
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (cmd_i.pre_limit) halt_q <= acpu_pkg::ST_LIMIT;
      if (cmd_i.fetch_use) begin
        pc_q  <= pc_q + 1'b1;
        buf_q <= rdata_q[acpu_pkg::HalfW-1:0];
      end else if (cmd_i.buf_use) begin
        buf_q <= '0;
      end
      if (cmd_i.exec) begin
        unique case (opcode)
          acpu_pkg::OpLoad:  acc_q <= low;
          acpu_pkg::OpJump:  pc_q <= iaddr - 1'b1;
          acpu_pkg::OpJumpP: if (!acc_q[acpu_pkg::RegW-1]) pc_q <= iaddr - 1'b1;
          acpu_pkg::OpAdd:   acc_q <= acc_q + low;
          acpu_pkg::OpSub:   acc_q <= acc_q - low;
          acpu_pkg::OpDiv:   if (rdata_q == '0) halt_q <= acpu_pkg::ST_DIVZERO;
          acpu_pkg::OpEnd:   halt_q <= acpu_pkg::ST_END;
          default: ;
        endcase
      end
      if (cmd_i.mul) acc_q <= acc_q * low;
      if (cmd_i.div_fix) begin
        acc_q <= qneg_q ? (~quo_q + 1'b1) : quo_q;
        mq_q  <= rneg_q ? (~rem_q[acpu_pkg::RegW-1:0] + 1'b1) : rem_q[acpu_pkg::RegW-1:0];
      end
      if (cmd_i.limit_chk && halt_q == acpu_pkg::ST_RUN
          && {1'b0, pc_q} >= limit_q) begin
        halt_q <= acpu_pkg::ST_LIMIT;
      end
    end
  end

  always_comb begin
    stat_o.func      = func_q;
    stat_o.halted    = (halt_q != acpu_pkg::ST_RUN);
    stat_o.at_limit  = ({1'b0, pc_q} >= limit_q);
    stat_o.buf_empty = (buf_q == '0);
    stat_o.opcode    = opcode;
    stat_o.div_zero  = (rdata_q == '0);
    stat_o.div_done  = (cnt_q == CntW'(acpu_pkg::RegW - 1));
  end

  assign read_data_o = read_q;
  assign acc_o       = acc_q;
  assign mq_o        = mq_q;
  assign pc_o        = pc_q;
  assign status_o    = halt_q;

endmodule

[hw/rtl/accumulator_cpu_fetch_execute_top.sv]
// Accumulator CPU top level. Division uses the one-bit-per-cycle divider. One
// item at a time. rst_ni clears acc, mq, pc, the instruction buffer and the
// halt status and sets pc_limit to 10; the word memory is not cleared.
// Depends on acpu_pkg, acpu_ctrl and acpu_dpath.
`timescale 1ns / 1ps
module accumulator_cpu_fetch_execute_top #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: func[1:0], address[13:2], write_data[53:14], zero pad to 56 bits.
  input  logic [55:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: read_data[39:0], acc_value[71:40], mq_value[103:72],
  // pc_value[115:104], status[117:116], zero pad to 120 bits.
  output logic [119:0]  m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [12:0]   cfg_data_i
);

  acpu_pkg::cmd_t  cmd;
  acpu_pkg::stat_t stat;
  logic [39:0] read_data;
  logic [31:0] acc, mq;
  logic [11:0] pc;
  logic [1:0]  status;

  // The user must write the limit register only while idle; it is not enforced.
  assign cfg_ready_o = 1'b1;

  acpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  acpu_dpath #(.MemWords(MEM_WORDS)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (s_axis_tdata[1:0]),
    .address_i    (s_axis_tdata[13:2]),
    .write_data_i (s_axis_tdata[53:14]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .read_data_o  (read_data),
    .acc_o        (acc),
    .mq_o         (mq),
    .pc_o         (pc),
    .status_o     (status)
  );

  // Result beat is read straight from the architectural registers while shown.
  assign m_axis_tdata = {2'b00, status, pc, mq, acc, read_data};

endmodule

[hw/rtl/acpu_checker.sv]
// Port checker for the accumulator CPU top level, bound to it below.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acpu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);

  `ASSERT_CLK(out_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_CLK(no_overlap, !(s_axis_tready && m_axis_tvalid))
  `ASSERT_CLK(no_instant, s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
  `ASSERT_ALWAYS(pad_zero, m_axis_tdata[119:118] == 2'b00)

endmodule

bind accumulator_cpu_fetch_execute_top acpu_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
